FILE: rtl/dmlh_pkg.sv
// Shared types, codes and constants of the line hull block.
package dmlh_pkg;

   localparam int CAPACITY_DEF = 64;

   localparam logic signed [63:0] INF_END = 64'sd4000000000000000000;

   typedef enum logic {
      CMD_ADD   = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [31:0] slope;
      logic signed [60:0] icpt;
      logic signed [63:0] rend;
   } line_type;

endpackage

FILE: rtl/dmlh_ifs.sv
// Request and response channel interfaces of the line hull block.
interface dmlh_req_if;
   import dmlh_pkg::*;
   logic               valid;
   logic               ready;
   cmd_type            command;
   logic signed [31:0] slope;
   logic signed [60:0] intercept;
   logic signed [31:0] query_x;
   modport source (output valid, command, slope, intercept, query_x, input ready);
   modport sink   (input valid, command, slope, intercept, query_x, output ready);
endinterface

interface dmlh_rsp_if;
   import dmlh_pkg::*;
   logic               valid;
   logic               ready;
   logic signed [63:0] result_value;
   status_type         status;
   modport source (output valid, result_value, status, input ready);
   modport sink   (input valid, result_value, status, output ready);
endinterface

FILE: rtl/dynamic_max_line_hull_core.sv
// Upper envelope of lines: sorted line store, sequencer and shared divider.
//
//   channel  | dir | payload                              | handshake
//   ---------+-----+--------------------------------------+-------------
//   req_ch   | in  | command, slope, intercept, query_x   | valid/ready
//   rsp_ch   | out | result_value, status                 | valid/ready
//
// One request at a time. A query scans the lines up to the first whose right
// end reaches x. An add shifts steeper lines up, recomputes right ends with
// the 62-step restoring divider and shifts lines down on each removal; the
// store has one read and one write port, and its reads are registered. Reset
// (synchronous) empties the store via the line count; no clearing pass.
// req_ch.ready is high only in idle; a finished response waits in the
// output register and the next request may be taken meanwhile.
module dynamic_max_line_hull_core #(
   parameter int CAPACITY = dmlh_pkg::CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   dmlh_req_if.sink    req_ch,
   dmlh_rsp_if.source  rsp_ch
);
   import dmlh_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [4:0] {
      S_IDLE, S_INS_CHK, S_INS_EVAL, S_INS_WR,
      S_SET_RD, S_SET_CALC, S_SET_DIV, S_SET_FIX, S_SET_WR, S_SET_RET,
      S_RM_CHK, S_RM_WR, S_BK_RD, S_BK_EVAL, S_BK_NEXT,
      S_Q_RD, S_Q_EVAL, S_Q_ADD, S_FINISH
   } state_type;

   typedef enum logic [1:0] {
      PH_FWD, PH_BK_FIRST, PH_BK_RESETTLE, PH_BK_LOOP
   } phase_type;

   state_type          state_ff;
   phase_type          phase_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   j_ff;
   logic [IDX_W-1:0]   ia_ff;

   // latched request
   logic signed [31:0] k_ff;
   logic signed [60:0] b_ff;
   logic signed [31:0] qx_ff;

   // line under settlement and its successor's right end
   logic signed [31:0] a_slope_ff;
   logic signed [60:0] a_icpt_ff;
   logic signed [63:0] a_rend_ff;
   logic signed [63:0] b_rend_ff;
   logic signed [63:0] prev_rend_ff;
   logic               flag_ff;

   // shared divider
   logic [61:0]        quo_ff;
   logic [32:0]        rem_ff;
   logic [32:0]        dm_ff;
   logic               neg_ff;
   logic [5:0]         dcnt_ff;

   // query datapath
   logic signed [63:0] prod_ff;
   logic signed [60:0] q_icpt_ff;

   // result
   logic signed [63:0] res_value_ff;
   status_type         res_status_ff;
   logic               rsp_valid_ff;
   logic signed [63:0] rsp_value_ff;
   status_type         rsp_status_ff;

   // line store
   line_type           line_store_ff [CAPACITY];
   line_type           rd_line_ff;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_wa;
   logic [IDX_W-1:0]   mem_ra;
   line_type           mem_wd;

   logic [CNT_W-1:0]   j_m1;
   logic [CNT_W-1:0]   j_p1;
   logic [CNT_W-1:0]   ia_p1;
   logic signed [63:0] qx64;
   logic signed [61:0] dnum;
   logic signed [32:0] dden;
   logic [61:0]        dnum_mag;
   logic [32:0]        dden_mag;
   logic [33:0]        rem_sh;
   logic [33:0]        rem_sub;
   logic               rem_ge;
   logic signed [63:0] fix_q;
   logic signed [63:0] prod_w;

   assign j_m1  = j_ff - CNT_W'(1);
   assign j_p1  = j_ff + CNT_W'(1);
   assign ia_p1 = CNT_W'(ia_ff) + CNT_W'(1);
   assign qx64  = {{32{qx_ff[31]}}, qx_ff};

   // divider set-up: numerator b_next - b_this, denominator k_this - k_next
   assign dnum = {rd_line_ff.icpt[60], rd_line_ff.icpt} - {a_icpt_ff[60], a_icpt_ff};
   assign dden = {a_slope_ff[31], a_slope_ff} - {rd_line_ff.slope[31], rd_line_ff.slope};
   assign dnum_mag = dnum[61] ? 62'(-dnum) : 62'(dnum);
   assign dden_mag = dden[32] ? 33'(-dden) : 33'(dden);

   // one restoring step per cycle
   assign rem_sh  = {rem_ff, quo_ff[61]};
   assign rem_ge  = (rem_sh >= {1'b0, dm_ff});
   assign rem_sub = rem_sh - {1'b0, dm_ff};
   assign fix_q   = {2'b00, quo_ff};

   assign prod_w  = rd_line_ff.slope * qx_ff;

   assign req_ch.ready        = (state_ff == S_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.result_value = rsp_value_ff;
   assign rsp_ch.status       = rsp_status_ff;

   // store port control
   always_comb begin
      mem_we = 1'b0;
      mem_wa = ia_ff;
      mem_ra = ia_ff;
      mem_wd = '{slope: a_slope_ff, icpt: a_icpt_ff, rend: a_rend_ff};
      unique case (state_ff)
         S_INS_CHK: mem_ra = j_m1[IDX_W-1:0];
         S_INS_EVAL: begin
            mem_we = (rd_line_ff.slope > k_ff);
            mem_wa = j_ff[IDX_W-1:0];
            mem_wd = rd_line_ff;
         end
         S_INS_WR: begin
            mem_we = 1'b1;
            mem_wa = j_ff[IDX_W-1:0];
            mem_wd = '{slope: k_ff, icpt: b_ff, rend: '0};
         end
         S_SET_RD: begin
            mem_ra = ia_p1[IDX_W-1:0];
            mem_we = (ia_p1 >= count_ff);
            mem_wd = '{slope: a_slope_ff, icpt: a_icpt_ff, rend: INF_END};
         end
         S_SET_WR: mem_we = 1'b1;
         S_RM_CHK: mem_ra = j_p1[IDX_W-1:0];
         S_RM_WR: begin
            mem_we = 1'b1;
            mem_wa = j_ff[IDX_W-1:0];
            mem_wd = rd_line_ff;
         end
         S_Q_RD: mem_ra = j_ff[IDX_W-1:0];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_store_ff[mem_wa] <= mem_wd;
      end
      rd_line_ff <= line_store_ff[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_FWD;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop the response once taken; a finishing request reloads it itself
         if (rsp_valid_ff && rsp_ch.ready && (state_ff != S_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  k_ff         <= req_ch.slope;
                  b_ff         <= req_ch.intercept;
                  qx_ff        <= req_ch.query_x;
                  res_value_ff <= '0;
                  if (req_ch.command == CMD_ADD) begin
                     j_ff <= count_ff;
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        res_status_ff <= ST_FULL;
                        state_ff      <= S_FINISH;
                     end else begin
                        res_status_ff <= ST_OK;
                        state_ff      <= S_INS_CHK;
                     end
                  end else begin
                     j_ff <= '0;
                     if (count_ff == '0) begin
                        res_status_ff <= ST_EMPTY;
                        state_ff      <= S_FINISH;
                     end else begin
                        res_status_ff <= ST_OK;
                        state_ff      <= S_Q_RD;
                     end
                  end
               end
            end

            // walk down from the top, moving steeper lines up one slot
            S_INS_CHK: begin
               state_ff <= (j_ff == '0) ? S_INS_WR : S_INS_EVAL;
            end
            S_INS_EVAL: begin
               if (rd_line_ff.slope > k_ff) begin
                  j_ff     <= j_m1;
                  state_ff <= S_INS_CHK;
               end else begin
                  state_ff <= S_INS_WR;
               end
            end
            S_INS_WR: begin
               count_ff   <= count_ff + CNT_W'(1);
               ia_ff      <= j_ff[IDX_W-1:0];
               a_slope_ff <= k_ff;
               a_icpt_ff  <= b_ff;
               phase_ff   <= PH_FWD;
               state_ff   <= S_SET_RD;
            end

            // recompute the right end of line ia against line ia+1
            S_SET_RD: begin
               if (ia_p1 >= count_ff) begin
                  a_rend_ff <= INF_END;
                  flag_ff   <= 1'b0;
                  state_ff  <= S_SET_RET;
               end else begin
                  state_ff <= S_SET_CALC;
               end
            end
            S_SET_CALC: begin
               b_rend_ff <= rd_line_ff.rend;
               if (a_slope_ff == rd_line_ff.slope) begin
                  a_rend_ff <= (a_icpt_ff > rd_line_ff.icpt) ? INF_END : -INF_END;
                  state_ff  <= S_SET_WR;
               end else begin
                  quo_ff   <= dnum_mag;
                  dm_ff    <= dden_mag;
                  rem_ff   <= '0;
                  neg_ff   <= dnum[61] ^ dden[32];
                  dcnt_ff  <= '0;
                  state_ff <= S_SET_DIV;
               end
            end
            S_SET_DIV: begin
               rem_ff  <= rem_ge ? rem_sub[32:0] : rem_sh[32:0];
               quo_ff  <= {quo_ff[60:0], rem_ge};
               dcnt_ff <= dcnt_ff + 6'd1;
               if (dcnt_ff == 6'd61) begin
                  state_ff <= S_SET_FIX;
               end
            end
            S_SET_FIX: begin
               // round the truncated quotient towards minus infinity
               if (neg_ff) begin
                  a_rend_ff <= -fix_q - ((rem_ff != '0) ? 64'sd1 : 64'sd0);
               end else begin
                  a_rend_ff <= fix_q;
               end
               state_ff <= S_SET_WR;
            end
            S_SET_WR: begin
               flag_ff  <= (a_rend_ff >= b_rend_ff);
               state_ff <= S_SET_RET;
            end
            S_SET_RET: begin
               unique case (phase_ff)
                  PH_FWD: begin
                     if (flag_ff) begin
                        j_ff     <= ia_p1;
                        state_ff <= S_RM_CHK;
                     end else if (ia_ff == '0) begin
                        state_ff <= S_FINISH;
                     end else begin
                        ia_ff    <= ia_ff - IDX_W'(1);
                        phase_ff <= PH_BK_FIRST;
                        state_ff <= S_BK_RD;
                     end
                  end
                  PH_BK_FIRST: begin
                     if (flag_ff) begin
                        j_ff     <= ia_p1;
                        state_ff <= S_RM_CHK;
                     end else begin
                        state_ff <= S_BK_NEXT;
                     end
                  end
                  default: state_ff <= S_BK_NEXT;
               endcase
            end

            // close the gap left by the removed line
            S_RM_CHK: begin
               if (j_p1 >= count_ff) begin
                  count_ff <= count_ff - CNT_W'(1);
                  if (phase_ff == PH_BK_FIRST) begin
                     phase_ff <= PH_BK_RESETTLE;
                  end
                  state_ff <= S_SET_RD;
               end else begin
                  state_ff <= S_RM_WR;
               end
            end
            S_RM_WR: begin
               j_ff     <= j_p1;
               state_ff <= S_RM_CHK;
            end

            // walk towards the shallow end dropping hidden lines
            S_BK_NEXT: begin
               if (ia_ff == '0) begin
                  state_ff <= S_FINISH;
               end else begin
                  prev_rend_ff <= a_rend_ff;
                  ia_ff        <= ia_ff - IDX_W'(1);
                  phase_ff     <= PH_BK_LOOP;
                  state_ff     <= S_BK_RD;
               end
            end
            S_BK_RD: state_ff <= S_BK_EVAL;
            S_BK_EVAL: begin
               a_slope_ff <= rd_line_ff.slope;
               a_icpt_ff  <= rd_line_ff.icpt;
               a_rend_ff  <= rd_line_ff.rend;
               if (phase_ff == PH_BK_FIRST) begin
                  state_ff <= S_SET_RD;
               end else if (rd_line_ff.rend >= prev_rend_ff) begin
                  j_ff     <= ia_p1;
                  state_ff <= S_RM_CHK;
               end else begin
                  state_ff <= S_FINISH;
               end
            end

            // query: find the first line whose right end reaches x
            S_Q_RD: state_ff <= S_Q_EVAL;
            S_Q_EVAL: begin
               if ((j_p1 < count_ff) && (rd_line_ff.rend < qx64)) begin
                  j_ff     <= j_p1;
                  state_ff <= S_Q_RD;
               end else begin
                  prod_ff   <= prod_w;
                  q_icpt_ff <= rd_line_ff.icpt;
                  state_ff  <= S_Q_ADD;
               end
            end
            S_Q_ADD: begin
               res_value_ff <= prod_ff + {{3{q_icpt_ff[60]}}, q_icpt_ff};
               state_ff     <= S_FINISH;
            end

            // hold until the output register is free
            S_FINISH: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_value_ff  <= res_value_ff;
                  rsp_status_ff <= res_status_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("line count above capacity");

   a_full_refused: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.command == CMD_ADD &&
       count_ff == CNT_W'(CAPACITY))
      |=> ($stable(count_ff) && state_ff == S_FINISH && res_status_ff == ST_FULL))
      else $error("add on full store not refused");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status != ST_OK) |-> (rsp_ch.result_value == '0))
      else $error("error response carries a value");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SET_DIV) |-> (dm_ff != '0))
      else $error("divider started with zero denominator");

endmodule

FILE: bench/dynamic_max_line_hull_core_test.sv
`timescale 1ns / 100ps
// Self-checking bench for the line hull core: random and directed requests, scoreboard check.
module dynamic_max_line_hull_core_test;
   import dmlh_pkg::*;

   typedef struct {
      longint     value;
      status_type status;
   } hull_answer_type;

   // Scoreboard: keeps its own copy of the hull and the answers still owed.
   class hull_scoreboard_type;
      localparam longint END_MAX = 64'sd4000000000000000000;

      longint          slopes[CAPACITY_DEF];
      longint          icpts[CAPACITY_DEF];
      longint          ends[CAPACITY_DEF];
      int              lines;
      hull_answer_type owed[$];
      int              errors;

      function new();
         lines  = 0;
         errors = 0;
      endfunction

      function longint floor_quot(longint num, longint den);
         longint q;
         q = num / den;
         if ((num % den) != 0 && ((num < 0) != (den < 0)))
            q = q - 1;
         return q;
      endfunction

      function void drop_line(int i);
         for (int j = i; j + 1 < lines; j++) begin
            slopes[j] = slopes[j + 1];
            icpts[j]  = icpts[j + 1];
            ends[j]   = ends[j + 1];
         end
         lines--;
      endfunction

      // Recompute where line a stops being the maximum; true when b has become useless.
      function bit recompute_end(int a, int b);
         if (b >= lines) begin
            ends[a] = END_MAX;
            return 0;
         end
         if (slopes[a] == slopes[b])
            ends[a] = (icpts[a] > icpts[b]) ? END_MAX : -END_MAX;
         else
            ends[a] = floor_quot(icpts[b] - icpts[a], slopes[a] - slopes[b]);
         return ends[a] >= ends[b];
      endfunction

      function void insert_line(longint k, longint b);
         int pos;
         int x;
         int y;
         pos = 0;
         while (pos < lines && slopes[pos] <= k)
            pos++;
         for (int j = lines; j > pos; j--) begin
            slopes[j] = slopes[j - 1];
            icpts[j]  = icpts[j - 1];
            ends[j]   = ends[j - 1];
         end
         slopes[pos] = k;
         icpts[pos]  = b;
         ends[pos]   = 0;
         lines++;
         y = pos;
         while (recompute_end(y, y + 1))
            drop_line(y + 1);
         x = y;
         if (x > 0) begin
            x--;
            if (recompute_end(x, y)) begin
               drop_line(y);
               void'(recompute_end(x, y));
            end
         end
         while (x > 0) begin
            y = x;
            x--;
            if (ends[x] >= ends[y]) begin
               drop_line(y);
               void'(recompute_end(x, y));
            end else begin
               break;
            end
         end
      endfunction

      // Note an accepted request and work out the answer it must produce.
      function void note_request(cmd_type cmd, longint k, longint b, longint qx);
         hull_answer_type a;
         int i;
         a.value  = 0;
         a.status = ST_OK;
         if (cmd == CMD_ADD) begin
            if (lines >= CAPACITY_DEF)
               a.status = ST_FULL;
            else
               insert_line(k, b);
         end else if (lines == 0) begin
            a.status = ST_EMPTY;
         end else begin
            i = 0;
            while (i + 1 < lines && ends[i] < qx)
               i++;
            a.value = slopes[i] * qx + icpts[i];
         end
         owed.push_back(a);
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $time, what);
         errors++;
      endtask

      task check_response(longint value, status_type status);
         hull_answer_type a;
         if (owed.size() == 0) begin
            report($sformatf("unexpected response value %0d status %s", value, status.name()));
            return;
         end
         a = owed.pop_front();
         if (status !== a.status)
            report($sformatf("status %s, wanted %s", status.name(), a.status.name()));
         if (value !== a.value)
            report($sformatf("value %0d, wanted %0d", value, a.value));
      endtask
   endclass

   logic clock;
   logic reset;
   bit   calm;
   int   rsp_hold;

   dmlh_req_if req_ch();
   dmlh_rsp_if rsp_ch();

   hull_scoreboard_type hull_sb = new();

   dynamic_max_line_hull_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #10 clock = ~clock;

   // Draw a random hold-off gap, which is zero during calm stretches.
   function automatic int draw_gap();
      if ($urandom_range(0, 49) == 0)
         calm = ~calm;
      return calm ? 0 : $urandom_range(0, 3);
   endfunction

   // Offer one request and wait for it to be taken; valid stays high for a back-to-back request.
   task automatic send_request(cmd_type cmd, logic signed [31:0] k,
                               logic signed [60:0] b, logic signed [31:0] qx);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.command   <= cmd;
      req_ch.slope     <= k;
      req_ch.intercept <= b;
      req_ch.query_x   <= qx;
      do @(posedge clock); while (!req_ch.ready);
      hull_sb.note_request(cmd, longint'(k), longint'(b), longint'(qx));
   endtask

   task automatic offer_line(logic signed [31:0] k, logic signed [60:0] b);
      send_request(CMD_ADD, k, b, 32'sd0);
   endtask

   task automatic ask_max(logic signed [31:0] qx);
      send_request(CMD_QUERY, 32'sd0, 61'sd0, qx);
   endtask

   function automatic logic signed [31:0] pick_slope();
      case ($urandom_range(0, 5))
         0:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         1, 2:    return $signed($urandom_range(0, 16)) - 8;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [60:0] pick_icpt();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0:       return $urandom_range(0, 1) ? {1'b0, {60{1'b1}}} : {1'b1, 60'd0};
         1, 2:    return 61'($signed($urandom_range(0, 2000)) - 1000);
         default: return bits[60:0];
      endcase
   endfunction

   function automatic logic signed [31:0] pick_x();
      case ($urandom_range(0, 5))
         0:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         1, 2:    return $signed($urandom_range(0, 200)) - 100;
         default: return $urandom;
      endcase
   endfunction

   // Response side: after a response is taken, drop ready for a hold-off drawn by draw_gap.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            hull_sb.check_response(rsp_ch.result_value, rsp_ch.status);
            rsp_hold = draw_gap();
            if (rsp_hold > 0)
               rsp_ch.ready <= 1'b0;
         end else if (!rsp_ch.ready) begin
            rsp_hold--;
            if (rsp_hold <= 0)
               rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      #200ms;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int order[$];
      int j;
      clock            = 1'b0;
      reset            = 1'b1;
      calm             = 1'b0;
      rsp_hold         = 0;
      req_ch.valid     = 1'b0;
      req_ch.command   = CMD_ADD;
      req_ch.slope     = '0;
      req_ch.intercept = '0;
      req_ch.query_x   = '0;
      rsp_ch.ready     = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty store, extremes, equal slopes both ways.
      ask_max(32'sd0);
      offer_line(32'sd0, 61'sd0);
      offer_line(32'sd0, 61'sd0);           // equal slope, equal intercept: older one disabled
      ask_max(32'sd5);
      offer_line(32'sd0, -61'sd1);          // equal slope, smaller intercept: dropped
      offer_line(32'sh7fffffff, {1'b0, {60{1'b1}}});
      offer_line(32'sh80000000, {1'b1, 60'd0});
      offer_line(32'sh80000000, {1'b0, {60{1'b1}}});
      ask_max(32'sh80000000);
      ask_max(32'sh7fffffff);
      ask_max(32'sd0);
      ask_max(-32'sd1);
      offer_line(32'sd3, 61'sd100);
      offer_line(32'sd3, 61'sd200);
      offer_line(-32'sd3, -61'sd50);
      offer_line(32'sd1, {1'b1, 60'd0});    // never reaches the envelope
      ask_max(32'sd1);
      ask_max(32'sd1000);
      ask_max(-32'sd1000);

      // Random mix of adds and queries.
      repeat (1530) begin
         if ($urandom_range(0, 9) < 6)
            offer_line(pick_slope(), pick_icpt());
         else
            ask_max(pick_x());
      end

      // Lines tangent to a parabola all stay on the hull: fill the store to capacity.
      for (int i = 0; i < 96; i++)
         order.push_back(i);
      order.shuffle();
      foreach (order[i]) begin
         j = order[i] - 48;
         offer_line(j * 32'sd16777216, (61'sd1 <<< 59) - ((61'(j * j)) <<< 46));
         if ($urandom_range(0, 2) == 0)
            ask_max(pick_x());
      end
      offer_line(32'sd7, 61'sd7);
      ask_max(32'sd0);

      req_ch.valid <= 1'b0;
      while (hull_sb.owed.size() != 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
      if (hull_sb.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule
